>>> sv/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and constants for the two-class priority queue
// Item formats, mode codes, cell control group and default sizes.
// ----------------------------------------------------------------------------
package tcpq_pkg;

   localparam int DEPTH_DEF   = 16;
   localparam int ID_BITS_DEF = 16;

   typedef enum logic [1:0] {
      MODE_PRIO = 2'd0,
      MODE_TAIL = 2'd1,
      MODE_DEQ  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] client_id;
      logic        priority_flag;
   } req_type;

   typedef struct packed {
      logic [15:0] out_client_id;
      logic        out_valid;
      logic        was_empty;
      logic        dropped_full;
      logic [4:0]  occupancy;
   } rsp_type;

   // control broadcast to every cell
   typedef struct packed {
      logic ins;       // insert an entry this cycle
      logic deq;       // remove the head this cycle
      logic prio_ins;  // insert after the leading priority run
   } ctl_type;

endpackage

>>> sv/tcpq_cell.sv
// ----------------------------------------------------------------------------
// tcpq_cell: one queue slot
// Holds one entry and takes a new value from itself, the new item, the
// cell before it (insert shift) or the cell after it (dequeue shift).
// ----------------------------------------------------------------------------
module tcpq_cell #(
   parameter int ID_BITS = tcpq_pkg::ID_BITS_DEF
) (
   input  logic                 clock,
   input  tcpq_pkg::ctl_type    ctl,
   input  logic                 occ,        // slot lies below the count
   input  logic                 pre_in,     // every earlier slot is kept
   output logic                 pre_out,
   input  logic [ID_BITS-1:0]   new_id,
   input  logic                 new_prio,
   input  logic [ID_BITS-1:0]   prev_id,
   input  logic                 prev_prio,
   input  logic [ID_BITS-1:0]   next_id,
   input  logic                 next_prio,
   output logic [ID_BITS-1:0]   id,
   output logic                 prio
);

   logic [ID_BITS-1:0] id_ff, id_in;
   logic               prio_ff, prio_in;
   logic               keep;

   // a kept slot stays in front of the insert point
   assign keep    = occ & (ctl.prio_ins ? prio_ff : 1'b1);
   assign pre_out = pre_in & keep;

   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      if (ctl.ins) begin
         if (pre_in && !keep) begin
            id_in   = new_id;
            prio_in = new_prio;
         end else if (!pre_in) begin
            id_in   = prev_id;
            prio_in = prev_prio;
         end
      end else if (ctl.deq) begin
         id_in   = next_id;
         prio_in = next_prio;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

   assign id   = id_ff;
   assign prio = prio_ff;

endmodule

>>> sv/two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue: bounded queue of client ids with two classes
// A row of DEPTH slot cells, head in cell 0, shifted in place by each insert or dequeue.
// ----------------------------------------------------------------------------
// Result: the result of an item is registered and shows on rsp_strobe in the cycle after start.
// Throughput: one item per cycle; busy stays low, every slot cell moves in
//   the same cycle, so the insert-point ripple along the row sets the clock.
// Reset: synchronous, clears the entry count and the result strobe; slot
//   contents are not cleared and are only read below the count.
// Results cannot be stalled: each is shown for exactly one cycle.
module two_class_priority_queue #(
   parameter int DEPTH   = tcpq_pkg::DEPTH_DEF,
   parameter int ID_BITS = tcpq_pkg::ID_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tcpq_pkg::req_type req_item,
   output logic              rsp_strobe,
   output tcpq_pkg::rsp_type rsp_item
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // entry count, the only state that reset touches besides the strobe
   logic [CNT_W-1:0] count_ff, count_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   tcpq_pkg::rsp_type rsp_ff, rsp_in;

   logic              accept;
   logic              is_enq, is_deq;
   logic              full, empty;
   tcpq_pkg::ctl_type ctl;
   logic [ID_BITS-1:0] new_id;

   // per-slot wiring along the row
   logic [ID_BITS-1:0] cell_id   [DEPTH];
   logic               cell_prio [DEPTH];
   logic [DEPTH:0]     pre;     // pre[i]: all slots before i stay in front

   // The queue completes each item at the clock edge that takes it, so it never holds off start.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   assign is_enq = (req_item.mode == tcpq_pkg::MODE_PRIO) ||
                   (req_item.mode == tcpq_pkg::MODE_TAIL);
   assign is_deq = (req_item.mode == tcpq_pkg::MODE_DEQ);

   // A priority-mode insert of a priority entry goes after the leading
   // priority run; every other insert goes behind the last held entry.
   assign ctl.ins      = accept & is_enq & ~full;
   assign ctl.deq      = accept & is_deq & ~empty;
   assign ctl.prio_ins = (req_item.mode == tcpq_pkg::MODE_PRIO) &
                         req_item.priority_flag;

   // id is cut or zero-extended to the stored width
   assign new_id = ID_BITS'(req_item.client_id);

   assign pre[0] = 1'b1;

   // row of slot cells; cell 0 is the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int PREV = (i == 0) ? 0 : i - 1;
      localparam int NEXT = (i == DEPTH - 1) ? i : i + 1;
      logic occ;

      assign occ = (CNT_W'(i) < count_ff);

      tcpq_cell #(
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occ       (occ),
         .pre_in    (pre[i]),
         .pre_out   (pre[i+1]),
         .new_id    (new_id),
         .new_prio  (req_item.priority_flag),
         .prev_id   (cell_id[PREV]),
         .prev_prio (cell_prio[PREV]),
         .next_id   (cell_id[NEXT]),
         .next_prio (cell_prio[NEXT]),
         .id        (cell_id[i]),
         .prio      (cell_prio[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.deq) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // result of the item taken this cycle
   always_comb begin
      rsp_in               = '0;
      rsp_in.occupancy     = 5'(count_in);
      rsp_in.dropped_full  = is_enq & full;
      rsp_in.was_empty     = is_deq & empty;
      rsp_in.out_valid     = ctl.deq;
      if (ctl.deq) begin
         rsp_in.out_client_id = 16'(cell_id[0]);
      end
   end

   assign rsp_strobe_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

>>> sv/tcpq_checker.sv
// ----------------------------------------------------------------------------
// tcpq_checker: port-level checks for the two-class priority queue
// Watches item timing and result flag consistency on the top-level ports.
// ----------------------------------------------------------------------------
module tcpq_checker #(
   parameter int DEPTH = tcpq_pkg::DEPTH_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input tcpq_pkg::rsp_type rsp_item
);

   // every taken item yields its result on the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("item without result");

   // no result without an item
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without item");

   // at most one outcome flag per result
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot0({rsp_item.out_valid, rsp_item.was_empty,
                               rsp_item.dropped_full}))
      else $error("conflicting result flags");

   // id is zero unless a dequeue delivered an entry
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.out_valid) |-> (rsp_item.out_client_id == 16'd0))
      else $error("stray client id");

   // a drop is only reported with a full queue
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.dropped_full) |-> (rsp_item.occupancy == 5'(DEPTH)))
      else $error("drop while not full");

endmodule

bind two_class_priority_queue tcpq_checker #(.DEPTH(DEPTH)) u_tcpq_checker (.*);
